// ----- hdl/dual_ultrasonic_ranger_guard_defines.svh -----
// Assertion macros for the dual ultrasonic ranger guard.
`ifndef DUAL_ULTRASONIC_RANGER_GUARD_DEFINES_SVH
`define DUAL_ULTRASONIC_RANGER_GUARD_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DURG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dual ranger guard: same-cycle check failed");
// next-cycle implication
`define DURG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dual ranger guard: next-cycle check failed");
`else
`define DURG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define DURG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/dugrd_pkg.sv -----
// Types and constants for the dual ultrasonic ranger guard.
package dugrd_pkg;

	typedef logic [2:0] phase_t;

	localparam phase_t PH_SETTLE = 3'd0;
	localparam phase_t PH_PULSE  = 3'd1;
	localparam phase_t PH_WAIT   = 3'd2;
	localparam phase_t PH_HIGH   = 3'd3;
	localparam phase_t PH_GAP    = 3'd4;

	typedef logic [2:0] cfg_idx_t;

	localparam cfg_idx_t CFG_ECHO_TIMEOUT = 3'd0;
	localparam cfg_idx_t CFG_NEAR_LIMIT   = 3'd1;
	localparam cfg_idx_t CFG_REPEAT_GAP   = 3'd2;
	localparam cfg_idx_t CFG_TRIG_SETTLE  = 3'd3;
	localparam cfg_idx_t CFG_TRIG_PULSE   = 3'd4;
	localparam cfg_idx_t CFG_GUARD_ENABLE = 3'd5;

	localparam int CFG_DATA_W = 20;
	localparam int TICK_W     = 20;
	localparam int RANGE_W    = 19;
	localparam int TMO_W      = 16;

	localparam logic [TMO_W-1:0]   RST_ECHO_TIMEOUT = 16'd10000;
	localparam logic [9:0]         RST_NEAR_LIMIT   = 10'd25;
	localparam logic [TICK_W-1:0]  RST_REPEAT_GAP   = 20'd50000;
	localparam logic [7:0]         RST_TRIG_SETTLE  = 8'd2;
	localparam logic [7:0]         RST_TRIG_PULSE   = 8'd10;

	// 0.0343 cm/us halved, in Q8 with an extra 8 fraction bits: 1124 / 65536
	localparam logic [10:0]        CM_Q8_SCALE = 11'd1124;
	localparam logic [RANGE_W-1:0] RANGE_MAX   = 19'd524287;

	typedef struct packed {
		logic               guard_clear_pulse;
		logic               guard_set_pulse;
		logic               guard_active;
		logic               fresh_left;
		logic               fresh_right;
		logic [RANGE_W-1:0] range_left_q8;
		logic [RANGE_W-1:0] range_right_q8;
		logic               trig_left;
		logic               trig_right;
	} result_t;

endpackage

// ----- hdl/dual_ultrasonic_ranger_guard.sv -----
// Dual ultrasonic ranger guard: trigger sequencing, echo timing and obstacle guard.
//
//   channel | dir | handshake          | payload
//   s_*     | in  | s_tvalid/s_tready  | s_tdata: one microsecond tick with both echo levels
//   m_*     | out | m_tvalid/m_tready  | m_tdata: trigger levels, ranges, fresh flags, guard
//   cfg_*   | in  | cfg_wen            | cfg_index, cfg_wdata: register write
//
// One tick per clock: the whole channel update is done in the accept cycle and the
// result lands in the output register, so the rate is one item a cycle.
// The output register sets the pace: s_tready drops only while a result is held by
// m_tready low. arst_n clears all channel state and loads the register defaults.
`include "dual_ultrasonic_ranger_guard_defines.svh"

module dual_ultrasonic_ranger_guard
	import dugrd_pkg::*;
#(
	parameter int CHANNEL_COUNT = 2,
	parameter int WIDTH_BITS    = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [0] echo_right, [1] echo_left, [7:2] zero
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [0] trig_right, [1] trig_left, [20:2] range_right_q8, [39:21] range_left_q8,
	// [40] fresh_right, [41] fresh_left, [42] guard_active, [43] guard_set_pulse,
	// [44] guard_clear_pulse, [47:45] zero
	output logic [47:0]           m_tdata,
	input  logic                  cfg_wen,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// effective timeout width: the timeout register or the width cap, whichever is narrower
	localparam int TW   = (WIDTH_BITS < TMO_W) ? WIDTH_BITS : TMO_W;
	localparam int PW   = TW + 11;
	localparam int HAS1 = (CHANNEL_COUNT > 1) ? 1 : 0;

	logic [TMO_W-1:0]  echo_timeout_q;
	logic [9:0]        near_limit_q;
	logic [TICK_W-1:0] repeat_gap_q;
	logic [7:0]        trig_settle_q;
	logic [7:0]        trig_pulse_q;
	logic              guard_enable_q;

	phase_t             ph_q [CHANNEL_COUNT];
	logic [TICK_W-1:0]  tk_q [CHANNEL_COUNT];
	logic [TW-1:0]      wd_q [CHANNEL_COUNT];
	logic [RANGE_W-1:0] rg_q [CHANNEL_COUNT];
	logic               guard_q;

	phase_t             ph_n [CHANNEL_COUNT];
	logic [TICK_W-1:0]  tk_n [CHANNEL_COUNT];
	logic [TW-1:0]      wd_n [CHANNEL_COUNT];
	logic [RANGE_W-1:0] rg_n [CHANNEL_COUNT];
	logic [PW-1:0]      prod [CHANNEL_COUNT];
	logic [CHANNEL_COUNT-1:0] trig_n;
	logic [CHANNEL_COUNT-1:0] fresh_n;
	logic [CHANNEL_COUNT-1:0] echo_c;

	logic [TW-1:0]      tmo;
	logic [7:0]         pulse_eff;
	logic [RANGE_W-1:0] limit_q8;
	logic               near;
	logic               guard_n;
	logic               set_n;
	logic               clr_n;

	result_t out_d;
	result_t out_q;
	logic    out_valid_q;
	logic    s_acc;

	assign s_tready = !out_valid_q || m_tready;
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_timeout_q <= RST_ECHO_TIMEOUT;
			near_limit_q   <= RST_NEAR_LIMIT;
			repeat_gap_q   <= RST_REPEAT_GAP;
			trig_settle_q  <= RST_TRIG_SETTLE;
			trig_pulse_q   <= RST_TRIG_PULSE;
			guard_enable_q <= 1'b1;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_ECHO_TIMEOUT: echo_timeout_q <= cfg_wdata[TMO_W-1:0];
				CFG_NEAR_LIMIT:   near_limit_q   <= cfg_wdata[9:0];
				CFG_REPEAT_GAP:   repeat_gap_q   <= cfg_wdata;
				CFG_TRIG_SETTLE:  trig_settle_q  <= cfg_wdata[7:0];
				CFG_TRIG_PULSE:   trig_pulse_q   <= cfg_wdata[7:0];
				CFG_GUARD_ENABLE: guard_enable_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(echo_timeout_q) > ((32'd1 << WIDTH_BITS) - 32'd1)) begin
			tmo = '1;
		end else begin
			tmo = TW'(echo_timeout_q);
		end
		pulse_eff = (trig_pulse_q == 8'd0) ? 8'd1 : trig_pulse_q;
		limit_q8  = {1'b0, near_limit_q, 8'b0};
	end

	// per-channel tick update
	always_comb begin
		near = 1'b0;
		for (int c = 0; c < CHANNEL_COUNT; c++) begin
			ph_n[c]    = ph_q[c];
			tk_n[c]    = tk_q[c];
			wd_n[c]    = wd_q[c];
			rg_n[c]    = rg_q[c];
			trig_n[c]  = 1'b0;
			fresh_n[c] = 1'b0;
			prod[c]    = PW'(wd_q[c]) * PW'(CM_Q8_SCALE);
			echo_c[c]  = (c == 0) ? s_tdata[0] : (c == 1) ? s_tdata[1] : 1'b0;

			if (ph_n[c] > PH_GAP) begin
				ph_n[c] = PH_SETTLE;
				tk_n[c] = '0;
			end
			// zero-length gap and settle fall through within the same tick
			if (ph_n[c] == PH_GAP && tk_n[c] >= repeat_gap_q) begin
				ph_n[c] = PH_SETTLE;
				tk_n[c] = '0;
			end
			if (ph_n[c] == PH_SETTLE && tk_n[c] >= TICK_W'(trig_settle_q)) begin
				ph_n[c] = PH_PULSE;
				tk_n[c] = '0;
			end

			unique case (ph_n[c])
				PH_SETTLE, PH_GAP: begin
					tk_n[c] = tk_n[c] + 1'b1;
				end
				PH_PULSE: begin
					trig_n[c] = 1'b1;
					tk_n[c]   = tk_n[c] + 1'b1;
					if (tk_n[c] >= TICK_W'(pulse_eff)) begin
						ph_n[c] = PH_WAIT;
						tk_n[c] = '0;
					end
				end
				PH_WAIT: begin
					if (echo_c[c]) begin
						ph_n[c] = PH_HIGH;
						wd_n[c] = TW'(1);
						tk_n[c] = '0;
					end else begin
						tk_n[c] = tk_n[c] + 1'b1;
						if (tk_n[c] > TICK_W'(tmo)) begin
							rg_n[c]    = '0;
							fresh_n[c] = 1'b1;
							ph_n[c]    = PH_GAP;
							tk_n[c]    = '0;
							wd_n[c]    = '0;
						end
					end
				end
				PH_HIGH: begin
					if (echo_c[c] && wd_q[c] < tmo) begin
						wd_n[c] = wd_q[c] + 1'b1;
					end else begin
						fresh_n[c] = 1'b1;
						ph_n[c]    = PH_GAP;
						tk_n[c]    = '0;
						wd_n[c]    = '0;
						if (echo_c[c] || wd_q[c] > tmo) begin
							rg_n[c] = '0;
						end else if (32'(prod[c][PW-1:8]) > 32'(RANGE_MAX)) begin
							rg_n[c] = RANGE_MAX;
						end else begin
							rg_n[c] = RANGE_W'(prod[c][PW-1:8]);
						end
					end
				end
				default: begin
					ph_n[c] = PH_SETTLE;
					tk_n[c] = '0;
				end
			endcase

			if (rg_n[c] != '0 && rg_n[c] <= limit_q8) begin
				near = 1'b1;
			end
		end
	end

	always_comb begin
		guard_n = guard_q;
		set_n   = 1'b0;
		clr_n   = 1'b0;
		if (guard_enable_q) begin
			set_n   = near && !guard_q;
			clr_n   = !near && guard_q;
			guard_n = near;
		end

		out_d.trig_right        = trig_n[0];
		out_d.range_right_q8    = rg_n[0];
		out_d.fresh_right       = fresh_n[0];
		out_d.trig_left         = trig_n[HAS1] & (HAS1 == 1);
		out_d.range_left_q8     = rg_n[HAS1] & {RANGE_W{HAS1 == 1}};
		out_d.fresh_left        = fresh_n[HAS1] & (HAS1 == 1);
		out_d.guard_active      = guard_n;
		out_d.guard_set_pulse   = set_n;
		out_d.guard_clear_pulse = clr_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNEL_COUNT; c++) begin
				ph_q[c] <= PH_SETTLE;
				tk_q[c] <= '0;
				wd_q[c] <= '0;
				rg_q[c] <= '0;
			end
			guard_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (s_acc) begin
			for (int c = 0; c < CHANNEL_COUNT; c++) begin
				ph_q[c] <= ph_n[c];
				tk_q[c] <= tk_n[c];
				wd_q[c] <= wd_n[c];
				rg_q[c] <= rg_n[c];
			end
			guard_q     <= guard_n;
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			out_q <= out_d;
		end
	end

	`DURG_ASSERT_IMPLIES(a_pulses_exclusive, clk, arst_n, m_tvalid, !(out_q.guard_set_pulse && out_q.guard_clear_pulse))
	`DURG_ASSERT_IMPLIES(a_set_raises_flag, clk, arst_n, m_tvalid && out_q.guard_set_pulse, out_q.guard_active && guard_q)
	`DURG_ASSERT_NEXT(a_fresh_enters_gap, clk, arst_n, s_acc && out_d.fresh_right, ph_q[0] == PH_GAP && tk_q[0] == '0)
	`DURG_ASSERT_IMPLIES(a_trig_in_pulse, clk, arst_n, m_tvalid && out_q.trig_right, ph_q[0] == PH_PULSE || ph_q[0] == PH_WAIT)

endmodule
